### hdl/stuffed_frame_receiver_top_defines.svh
// ----------------------------------------------------------------------------
// stuffed frame receiver: assertion macros
// shared helpers for the checker, clocked on the rising edge
// ----------------------------------------------------------------------------
`ifndef STUFFED_FRAME_RECEIVER_TOP_DEFINES_SVH
`define STUFFED_FRAME_RECEIVER_TOP_DEFINES_SVH

// property checked only outside reset
`define SRX_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define SRX_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/srx_pkg.sv
// ----------------------------------------------------------------------------
// srx_pkg
// types, codes and reset values for the stuffed frame receiver
// ----------------------------------------------------------------------------
package srx_pkg;

  // default payload limit in bytes
  localparam int unsigned SRX_MAX_PAYLOAD = 1024;

  // xor applied to the byte that follows an escape
  localparam logic [7:0] STUFF_MASK = 8'h20;

  // configuration register indices
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_FLAG  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL1 = 3'd4;

  // configuration reset values
  localparam logic [7:0] RST_FLAG  = 8'h7E;
  localparam logic [7:0] RST_ADDR  = 8'h03;
  localparam logic [7:0] RST_ESC   = 8'h7D;
  localparam logic [7:0] RST_CTRL0 = 8'h00;
  localparam logic [7:0] RST_CTRL1 = 8'h40;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_ADDR  = 3'd1,
    PH_CTRL  = 3'd2,
    PH_HCHK  = 3'd3,
    PH_DATA  = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    EV_NONE = 3'd0,
    EV_GOOD = 3'd1,
    EV_ADDR = 3'd2,
    EV_CTRL = 3'd3,
    EV_HCHK = 3'd4,
    EV_DCHK = 3'd5,
    EV_OVER = 3'd6
  } event_e;

endpackage

### hdl/stuffed_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// stuffed_frame_receiver_top
// byte-stuffed frame receiver: header checks, destuffing, data check
// ----------------------------------------------------------------------------
// usage
//   input channel: one line byte plus the expected frame number per transfer
//   (in_valid_i / in_ready_o). output channel: exactly one result per input
//   transfer (out_valid_o / out_ready_i) carrying an optional destuffed
//   payload byte with its index, an event code and the frame length.
//   configuration: cfg_we_i writes cfg_data_i into register cfg_index_i in
//   the same cycle; indices above four are dropped. write only when idle.
// latency and throughput
//   the result of a transfer is in the output register in the cycle after
//   it is taken. one byte per cycle is sustained while out_ready_i is high;
//   parser state and output register both update in the accepting cycle,
//   and the step is a few byte compares, one xor and one counter increment.
// reset
//   parser returns to the start phase, count, escape and check xor are
//   cleared, registers take their default values, output register empties.
// stall
//   while a result waits and out_ready_i is low, in_ready_o is low and the
//   parser holds; a taken result frees the register in that same cycle.
// ----------------------------------------------------------------------------
module stuffed_frame_receiver_top
  import srx_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = SRX_MAX_PAYLOAD,
  // count must reach MAX_PAYLOAD + 1 to flag overflow
  localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 2)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  // line byte input
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           line_byte_i,
  input  logic                 frame_number_i,
  // result output
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 payload_valid_o,
  output logic [7:0]           payload_byte_o,
  output logic [CNT_W-1:0]     payload_index_o,
  output logic [2:0]           event_res_o,
  output logic [CNT_W-1:0]     frame_length_o
);

  localparam logic [CNT_W-1:0] CNT_OVER = CNT_W'(MAX_PAYLOAD + 1);

  // configuration registers
  logic [7:0] flag_q, addr_q, esc_byte_q, ctrl0_q, ctrl1_q;

  // parser state
  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             esc_q, esc_d;
  logic [7:0]       xor_q, xor_d;

  // result register
  logic             out_valid_q;
  logic             pvalid_q, pvalid_d;
  logic [7:0]       pbyte_q, pbyte_d;
  logic [CNT_W-1:0] pidx_q, pidx_d;
  event_e           ev_q, ev_d;
  logic [CNT_W-1:0] flen_q, flen_d;

  logic       in_xfer;
  logic [7:0] ctl;
  logic [7:0] destuffed;

  // the output register frees in the cycle its result is taken
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign ctl       = frame_number_i ? ctrl1_q : ctrl0_q;
  assign destuffed = esc_q ? (line_byte_i ^ STUFF_MASK) : line_byte_i;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q     <= RST_FLAG;
      addr_q     <= RST_ADDR;
      esc_byte_q <= RST_ESC;
      ctrl0_q    <= RST_CTRL0;
      ctrl1_q    <= RST_CTRL1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FLAG:  flag_q     <= cfg_data_i;
        CFG_ADDR:  addr_q     <= cfg_data_i;
        CFG_ESC:   esc_byte_q <= cfg_data_i;
        CFG_CTRL0: ctrl0_q    <= cfg_data_i;
        CFG_CTRL1: ctrl1_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_ADDR: begin
        // address compare wins over a repeated flag
        if (line_byte_i == addr_q) begin
          phase_d = PH_CTRL;
        end else if (line_byte_i != flag_q) begin
          phase_d = PH_START;
        end
      end
      PH_CTRL: begin
        if (line_byte_i == ctl) begin
          phase_d = PH_HCHK;
        end else if (line_byte_i == flag_q) begin
          phase_d = PH_ADDR;
        end else begin
          phase_d = PH_START;
        end
      end
      PH_HCHK: begin
        phase_d = (line_byte_i == (addr_q ^ ctl)) ? PH_DATA : PH_START;
      end
      PH_DATA: begin
        if (line_byte_i == flag_q || count_q >= CNT_OVER) begin
          phase_d = PH_START;
        end
      end
      default: begin
        phase_d = (line_byte_i == flag_q) ? PH_ADDR : PH_START;
      end
    endcase
  end

  // datapath state and result fields
  always_comb begin
    count_d  = count_q;
    esc_d    = esc_q;
    xor_d    = xor_q;
    pvalid_d = 1'b0;
    pbyte_d  = '0;
    pidx_d   = '0;
    ev_d     = EV_NONE;
    flen_d   = '0;
    case (phase_q)
      PH_ADDR: begin
        if (line_byte_i != addr_q && line_byte_i != flag_q) begin
          ev_d = EV_ADDR;
        end
      end
      PH_CTRL: begin
        if (line_byte_i != ctl && line_byte_i != flag_q) begin
          ev_d = EV_CTRL;
        end
      end
      PH_HCHK: begin
        if (line_byte_i != (addr_q ^ ctl)) begin
          ev_d = EV_HCHK;
        end
      end
      PH_DATA: begin
        if (line_byte_i == flag_q) begin
          // closing flag: any pending escape is dropped
          if (xor_q == 8'h00 && count_q != '0) begin
            ev_d   = EV_GOOD;
            flen_d = count_q - CNT_W'(1);
          end else begin
            ev_d = EV_DCHK;
          end
          count_d = '0;
          esc_d   = 1'b0;
        end else if (count_q >= CNT_OVER) begin
          ev_d = EV_OVER;
        end else if (esc_q || line_byte_i != esc_byte_q) begin
          esc_d    = 1'b0;
          pvalid_d = 1'b1;
          pbyte_d  = destuffed;
          pidx_d   = count_q;
          xor_d    = xor_q ^ destuffed;
          count_d  = count_q + CNT_W'(1);
        end else begin
          esc_d = 1'b1;
        end
      end
      default: begin
        // frame start clears the per-frame state
        if (line_byte_i == flag_q) begin
          count_d = '0;
          esc_d   = 1'b0;
          xor_d   = 8'h00;
        end
      end
    endcase
  end

  // parser state advances on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      count_q <= '0;
      esc_q   <= 1'b0;
      xor_q   <= 8'h00;
    end else if (in_xfer) begin
      phase_q <= phase_d;
      count_q <= count_d;
      esc_q   <= esc_d;
      xor_q   <= xor_d;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      pvalid_q <= pvalid_d;
      pbyte_q  <= pbyte_d;
      pidx_q   <= pidx_d;
      ev_q     <= ev_d;
      flen_q   <= flen_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign payload_valid_o = pvalid_q;
  assign payload_byte_o  = pbyte_q;
  assign payload_index_o = pidx_q;
  assign event_res_o     = ev_q;
  assign frame_length_o  = flen_q;

endmodule

### hdl/srx_checker.sv
// ----------------------------------------------------------------------------
// srx_checker
// port-level checks for the stuffed frame receiver, bound to the top level
// ----------------------------------------------------------------------------
`include "stuffed_frame_receiver_top_defines.svh"

module srx_checker
  import srx_pkg::*;
#(
  parameter int unsigned CNT_W = 11
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic             payload_valid_i,
  input logic [7:0]       payload_byte_i,
  input logic [CNT_W-1:0] payload_index_i,
  input logic [2:0]       event_res_i,
  input logic [CNT_W-1:0] frame_length_i
);

  // a stalled result holds
  `SRX_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(payload_byte_i) && $stable(event_res_i), "stalled result changed")

  // no result during reset
  `SRX_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |-> !out_valid_i, "result shown in reset")

  // an empty output register always takes a transfer
  `SRX_ASSERT(a_idle_ready, clk_i, rst_ni, !out_valid_i |-> in_ready_i, "not ready while empty")

  // a payload byte never comes with an event
  `SRX_ASSERT(a_pay_no_ev, clk_i, rst_ni, out_valid_i && payload_valid_i |-> event_res_i == EV_NONE, "payload with event")

  // length only reported for a good frame, payload fields zero when unused
  `SRX_ASSERT(a_len_good, clk_i, rst_ni, out_valid_i && (frame_length_i != '0 || (!payload_valid_i && (payload_byte_i != 8'h00 || payload_index_i != '0))) |-> event_res_i == EV_GOOD && !payload_valid_i && payload_byte_i == 8'h00 && payload_index_i == '0, "stray length or payload")

endmodule

bind stuffed_frame_receiver_top srx_checker #(
  .CNT_W(CNT_W)
) u_srx_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_ready_o),
  .out_valid_i    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .payload_valid_i(payload_valid_o),
  .payload_byte_i (payload_byte_o),
  .payload_index_i(payload_index_o),
  .event_res_i    (event_res_o),
  .frame_length_i (frame_length_o)
);

### sim/tb_stuffed_frame_receiver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stuffed_frame_receiver_top
// self-checking bench for the byte-stuffed frame receiver: a behavioural
// parser predicts one result per line byte and a scoreboard compares every
// result transfer field by field, across several register settings
// ----------------------------------------------------------------------------
module tb_stuffed_frame_receiver_top;
  import srx_pkg::*;

  localparam int unsigned IDX_W     = $clog2(SRX_MAX_PAYLOAD + 2);
  localparam int unsigned LIMIT     = 500000;  // watchdog, in clock cycles
  localparam int unsigned HOLD_OFF  = 300;     // long receiver stall
  localparam int unsigned PHASE_LEN = 175;     // random line bytes per setting

  typedef struct packed {
    logic             pay_valid;
    logic [7:0]       pay_byte;
    logic [IDX_W-1:0] pay_index;
    event_e           evt;
    logic [IDX_W-1:0] length;
  } rx_result_t;

  // shapes of frame the stimulus can build
  typedef enum int {
    FK_GOOD, FK_BAD_ADDR, FK_BAD_CTRL, FK_BAD_HCHK, FK_BAD_DCHK,
    FK_EMPTY, FK_REFLAG, FK_OPEN_ESC, FK_OVERFLOW, FK_NOISE
  } frame_kind_e;

  // --------------------------------------------------------------------------
  // scoreboard: own copy of the parser state and the registers
  // --------------------------------------------------------------------------
  class frame_scoreboard;
    logic [7:0]  regs [5];
    phase_e      phase;
    int unsigned data_cnt;
    logic        esc_pend;
    logic [7:0]  chk_xor;
    rx_result_t  exp_q [$];
    int          mismatches;
    int          results;
    int          bytes_in;
    int          bytes_out;
    int          ev_seen [7];

    function new();
      regs[CFG_FLAG]  = RST_FLAG;
      regs[CFG_ADDR]  = RST_ADDR;
      regs[CFG_ESC]   = RST_ESC;
      regs[CFG_CTRL0] = RST_CTRL0;
      regs[CFG_CTRL1] = RST_CTRL1;
      phase      = PH_START;
      data_cnt   = 0;
      esc_pend   = 1'b0;
      chk_xor    = 8'h00;
      mismatches = 0;
      results    = 0;
      bytes_in   = 0;
      bytes_out  = 0;
      foreach (ev_seen[i]) ev_seen[i] = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
      // spare indices are dropped by the block
      if (idx <= CFG_CTRL1) regs[idx] = val;
    endfunction

    // one accepted line byte gives exactly one expected result
    function void note_byte(logic [7:0] b, logic fn);
      rx_result_t r;
      logic [7:0] ctl;
      logic [7:0] d;
      r.pay_valid = 1'b0;
      r.pay_byte  = '0;
      r.pay_index = '0;
      r.evt       = EV_NONE;
      r.length    = '0;
      ctl = fn ? regs[CFG_CTRL1] : regs[CFG_CTRL0];
      bytes_in++;
      case (phase)
        PH_ADDR: begin
          // address compare first, a repeated flag keeps waiting
          if (b == regs[CFG_ADDR]) begin
            phase = PH_CTRL;
          end else if (b != regs[CFG_FLAG]) begin
            phase = PH_START;
            r.evt = EV_ADDR;
          end
        end
        PH_CTRL: begin
          if (b == ctl) begin
            phase = PH_HCHK;
          end else if (b == regs[CFG_FLAG]) begin
            phase = PH_ADDR;
          end else begin
            phase = PH_START;
            r.evt = EV_CTRL;
          end
        end
        PH_HCHK: begin
          if (b == (regs[CFG_ADDR] ^ ctl)) begin
            phase = PH_DATA;
          end else begin
            phase = PH_START;
            r.evt = EV_HCHK;
          end
        end
        PH_DATA: begin
          if (b == regs[CFG_FLAG]) begin
            // closing flag wins over a pending escape
            if (chk_xor == 8'h00 && data_cnt >= 1) begin
              r.evt    = EV_GOOD;
              r.length = IDX_W'(data_cnt - 1);
            end else begin
              r.evt = EV_DCHK;
            end
            data_cnt = 0;
            esc_pend = 1'b0;
            phase    = PH_START;
          end else if (data_cnt >= SRX_MAX_PAYLOAD + 1) begin
            r.evt = EV_OVER;
            phase = PH_START;
          end else if (esc_pend || b != regs[CFG_ESC]) begin
            d = esc_pend ? (b ^ STUFF_MASK) : b;
            esc_pend    = 1'b0;
            r.pay_valid = 1'b1;
            r.pay_byte  = d;
            r.pay_index = IDX_W'(data_cnt);
            chk_xor     = chk_xor ^ d;
            data_cnt++;
          end else begin
            esc_pend = 1'b1;
          end
        end
        default: begin
          // frame start clears count, escape and check
          if (b == regs[CFG_FLAG]) begin
            phase    = PH_ADDR;
            data_cnt = 0;
            esc_pend = 1'b0;
            chk_xor  = 8'h00;
          end else begin
            phase = PH_START;
          end
        end
      endcase
      exp_q.push_back(r);
    endfunction

    function void check_result(rx_result_t got);
      rx_result_t want;
      results++;
      if (exp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with nothing expected: ev=%0d byte=%02h",
                   results, got.evt, got.pay_byte);
      end else begin
        want = exp_q.pop_front();
        if (got.pay_valid !== want.pay_valid || got.pay_byte !== want.pay_byte ||
            got.pay_index !== want.pay_index || got.evt !== want.evt ||
            got.length !== want.length) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d: expected pv=%0b byte=%02h idx=%0d ev=%0d len=%0d",
                     results, want.pay_valid, want.pay_byte, want.pay_index,
                     want.evt, want.length);
            $display("result %0d: got      pv=%0b byte=%02h idx=%0d ev=%0d len=%0d",
                     results, got.pay_valid, got.pay_byte, got.pay_index,
                     got.evt, got.length);
          end
        end
        if (want.pay_valid) bytes_out++;
        ev_seen[want.evt]++;
      end
    endfunction

    function int pending();
      return exp_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // block under test
  // --------------------------------------------------------------------------
  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [7:0]           cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [7:0]           line_byte_i;
  logic                 frame_number_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic                 payload_valid_o;
  logic [7:0]           payload_byte_o;
  logic [IDX_W-1:0]     payload_index_o;
  logic [2:0]           event_res_o;
  logic [IDX_W-1:0]     frame_length_o;

  stuffed_frame_receiver_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .line_byte_i     (line_byte_i),
    .frame_number_i  (frame_number_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .payload_valid_o (payload_valid_o),
    .payload_byte_o  (payload_byte_o),
    .payload_index_o (payload_index_o),
    .event_res_o     (event_res_o),
    .frame_length_o  (frame_length_o)
  );

  frame_scoreboard sb;

  int          cycles      = 0;
  int          items_sent  = 0;
  int          burst_left  = 0;
  int          settings    = 0;
  logic        fast_sender = 1'b0;  // no gaps between transfers
  logic        pressure_go = 1'b0;
  logic        hold_off    = 1'b0;
  logic [15:0] stall_pat   = 16'hFFFF;
  int          pat_age     = 0;

  // 50 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles, sb.pending());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // monitor and receiver side
  // both channels are sampled on the edge, before any update lands, so the
  // result check sees the older transfer first and the input note follows
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_result('{payload_valid_o, payload_byte_o, payload_index_o,
                          event_e'(event_res_o), frame_length_o});
      if (in_valid_i && in_ready_o)
        sb.note_byte(line_byte_i, frame_number_i);
    end
    // receiver stall pattern, reloaded now and then; all-ones gives stretches
    // without any stall, bit zero is forced so a pattern never locks up
    pat_age++;
    if (pat_age == 64) begin
      pat_age   = 0;
      stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
    end else begin
      stall_pat = {stall_pat[0], stall_pat[15:1]};
    end
    out_ready_i <= hold_off ? 1'b0 : stall_pat[0];
  end

  // long receiver hold-off, counted here while the sender keeps offering
  initial begin
    while (!pressure_go) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_OFF) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // sender side
  // --------------------------------------------------------------------------

  // one line byte transfer; bursts of random length with random gaps
  task automatic send_item(input logic [7:0] b, input logic fn);
    int gap;
    if (burst_left == 0) begin
      gap = (fast_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i     <= 1'b1;
    line_byte_i    <= b;
    frame_number_i <= fn;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  // stop offering and wait until every owed result has been taken
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    // wait for the monitor to note the last transfer
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    // the output register's latency, plus a little margin
    repeat (3) @(posedge clk_i);
  endtask

  // full register set, then a write to a spare index that must be dropped
  task automatic apply_config(input logic [7:0] flag, input logic [7:0] addr,
                              input logic [7:0] esc, input logic [7:0] ctl0,
                              input logic [7:0] ctl1);
    logic [7:0]           vals [5];
    logic [CFG_IDX_W-1:0] spare;
    logic [7:0]           junk;
    vals[CFG_FLAG]  = flag;
    vals[CFG_ADDR]  = addr;
    vals[CFG_ESC]   = esc;
    vals[CFG_CTRL0] = ctl0;
    vals[CFG_CTRL1] = ctl1;
    for (int i = 0; i <= CFG_CTRL1; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= CFG_IDX_W'(i);
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      sb.set_reg(CFG_IDX_W'(i), vals[i]);
    end
    spare = CFG_IDX_W'($urandom_range(CFG_CTRL1 + 1, (1 << CFG_IDX_W) - 1));
    junk  = 8'($urandom());
    cfg_index_i <= spare;
    cfg_data_i  <= junk;
    @(posedge clk_i);
    sb.set_reg(spare, junk);
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  // build one frame under the current registers and send it
  task automatic send_frame(input frame_kind_e kind, input int len);
    logic [7:0] fr [$];
    logic [7:0] flag, addr, esc, ctl, b, chk;
    logic       fn;
    int         n;
    fn   = 1'($urandom_range(0, 1));
    flag = sb.regs[CFG_FLAG];
    addr = sb.regs[CFG_ADDR];
    esc  = sb.regs[CFG_ESC];
    ctl  = fn ? sb.regs[CFG_CTRL1] : sb.regs[CFG_CTRL0];
    chk  = 8'h00;
    if (kind == FK_NOISE) begin
      repeat ($urandom_range(1, 6)) send_item(8'($urandom()), 1'($urandom_range(0, 1)));
      return;
    end
    fr.push_back(flag);
    if (kind == FK_REFLAG) begin
      // repeated opening flag, sometimes a flag where the control belongs
      fr.push_back(flag);
      if ($urandom_range(0, 1) == 1) begin
        fr.push_back(addr);
        fr.push_back(flag);
      end
    end
    // header, truncated right after a broken field
    if (kind == FK_BAD_ADDR) begin
      do b = 8'($urandom()); while (b == addr || b == flag);
      fr.push_back(b);
    end else begin
      fr.push_back(addr);
      if (kind == FK_BAD_CTRL) begin
        do b = 8'($urandom()); while (b == ctl || b == flag);
        fr.push_back(b);
      end else begin
        fr.push_back(ctl);
        if (kind == FK_BAD_HCHK) begin
          fr.push_back(addr ^ ctl ^ 8'($urandom_range(1, 255)));
        end else begin
          fr.push_back(addr ^ ctl);
          // data plus check byte, stuffed; overflow frames carry no check
          n = (kind == FK_EMPTY) ? 0 : (kind == FK_OVERFLOW) ? len : len + 1;
          for (int i = 0; i < n; i++) begin
            if (kind != FK_OVERFLOW && i == len) begin
              b = (kind == FK_BAD_DCHK) ? (chk ^ 8'($urandom_range(1, 255))) : chk;
            end else begin
              b   = 8'($urandom());
              chk = chk ^ b;
            end
            // needless escapes now and then, unless they would read as a flag
            if (b == flag || b == esc ||
                ($urandom_range(0, 15) == 0 && (b ^ STUFF_MASK) != flag)) begin
              fr.push_back(esc);
              fr.push_back(b ^ STUFF_MASK);
            end else begin
              fr.push_back(b);
            end
          end
          // overflow hits on an escape byte; open escape is dropped at close
          if (kind == FK_OVERFLOW || kind == FK_OPEN_ESC) fr.push_back(esc);
          fr.push_back(flag);
        end
      end
    end
    foreach (fr[i]) send_item(fr[i], fn);
  endtask

  // mostly well-formed frames with random content, the rest broken or noise
  task automatic run_traffic(input int n_items);
    int          target;
    int          r;
    int          len;
    frame_kind_e kind;
    target = items_sent + n_items;
    while (items_sent < target) begin
      r = $urandom_range(0, 99);
      if      (r < 55) kind = FK_GOOD;
      else if (r < 62) kind = FK_BAD_ADDR;
      else if (r < 69) kind = FK_BAD_CTRL;
      else if (r < 76) kind = FK_BAD_HCHK;
      else if (r < 84) kind = FK_BAD_DCHK;
      else if (r < 88) kind = FK_EMPTY;
      else if (r < 93) kind = FK_REFLAG;
      else if (r < 96) kind = FK_OPEN_ESC;
      else             kind = FK_NOISE;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
      send_frame(kind, len);
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [8:0] directed [$];
    sb = new();
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = CFG_FLAG;
    cfg_data_i     = 8'h00;
    in_valid_i     = 1'b0;
    line_byte_i    = 8'h00;
    frame_number_i = 1'b0;
    out_ready_i    = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset registers; each entry is {frame number, line byte}
    //   idle byte in start phase
    //   repeated flag, flag in the control slot, frame 1 with escapes,
    //   a stuffed flag byte, an escaped escape and an escape left open at close
    //   empty frame, then a header check mismatch
    directed = '{9'h000,
                 9'h17E, 9'h17E, 9'h103, 9'h17E, 9'h103, 9'h140, 9'h143,
                 9'h17D, 9'h15E, 9'h1FF, 9'h17D, 9'h17D, 9'h1DC, 9'h17D, 9'h17E,
                 9'h07E, 9'h003, 9'h000, 9'h003, 9'h07E,
                 9'h07E, 9'h003, 9'h000, 9'h0FF};
    foreach (directed[i]) send_item(directed[i][7:0], directed[i][8]);
    drain();

    // reset registers, random traffic
    run_traffic(PHASE_LEN);
    drain();

    // longest good frame, then an overflow that lands on an escape byte
    fast_sender = 1'b1;
    send_frame(FK_GOOD, SRX_MAX_PAYLOAD);
    send_frame(FK_OVERFLOW, SRX_MAX_PAYLOAD + 1);
    fast_sender = 1'b0;
    run_traffic(20);
    drain();

    // low extremes; control 0 equals the flag, so the compare must win
    apply_config(8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF);
    pressure_go <= 1'b1;  // receiver stalls long while we keep offering
    run_traffic(PHASE_LEN);
    drain();

    // high extremes; address and control 0 equal the flag
    apply_config(8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00);
    run_traffic(PHASE_LEN);
    drain();

    // random register set
    apply_config(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()),
                 8'($urandom()));
    run_traffic(PHASE_LEN);
    drain();

    $display("covered %0d line bytes over %0d register settings: %0d results, %0d payload bytes",
             sb.bytes_in, settings + 1, sb.results, sb.bytes_out);
    $display("frames good %0d, bad address %0d, bad control %0d, bad header %0d",
             sb.ev_seen[EV_GOOD], sb.ev_seen[EV_ADDR], sb.ev_seen[EV_CTRL],
             sb.ev_seen[EV_HCHK]);
    $display("frames bad data %0d, overflow %0d",
             sb.ev_seen[EV_DCHK], sb.ev_seen[EV_OVER]);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatched results, %0d still owed", sb.mismatches, sb.pending());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
